// ===== sv/rps_pkg.sv =====
`default_nettype none

package rps_pkg;

    localparam int TW    = 16;
    localparam int SPW   = 13;
    localparam int SEGW  = 3;
    localparam int TEMPW = 9;
    localparam int RATEW = 12;
    localparam int DURW  = 10;
    localparam int LENW  = 21;
    localparam int BXW   = 23;
    localparam int QW    = 13;
    localparam int PRODW = 29;
    localparam int CFGW  = 12;
    localparam int IDXW  = 3;
    localparam int QDEPTH = 4;

    localparam logic [IDXW-1:0] REG_MODE      = 3'd0;
    localparam logic [IDXW-1:0] REG_START     = 3'd1;
    localparam logic [IDXW-1:0] REG_PRE_RATE  = 3'd2;
    localparam logic [IDXW-1:0] REG_SOAK_TEMP = 3'd3;
    localparam logic [IDXW-1:0] REG_SOAK_TIME = 3'd4;
    localparam logic [IDXW-1:0] REG_RAMP_RATE = 3'd5;
    localparam logic [IDXW-1:0] REG_PEAK_TEMP = 3'd6;
    localparam logic [IDXW-1:0] REG_PEAK_TIME = 3'd7;

    localparam logic [TEMPW-1:0] ROOM_TEMP   = 9'd25;
    localparam logic [2:0]       REFLOW_SEGS = 3'd5;
    localparam logic [2:0]       STERIL_SEGS = 3'd3;

    typedef struct packed {
        logic [5:0][BXW-1:0]   bx;
        logic [5:0][TEMPW-1:0] ty;
        logic [2:0]            nseg;
        logic [BXW:0]          door_sum;
        logic                  busy;
    } t_profile;

    typedef struct packed {
        logic [SEGW-1:0]  seg;
        logic             door;
        logic [TW-1:0]    dt;
        logic [TEMPW-1:0] mag;
        logic             neg;
        logic [SPW-1:0]   base;
        logic [BXW-1:0]   span;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/rps_bounds.sv =====
`default_nettype none

module rps_bounds import rps_pkg::*; #(
    parameter int MAX_SEGMENTS = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [IDXW-1:0] i_cfg_index,
    input  wire logic [CFGW-1:0] i_cfg_data,
    output t_profile             o_prof
);

    localparam logic [2:0] N_REFLOW = (MAX_SEGMENTS < 5) ? 3'(MAX_SEGMENTS) : REFLOW_SEGS;
    localparam logic [2:0] N_STERIL = (MAX_SEGMENTS < 3) ? 3'(MAX_SEGMENTS) : STERIL_SEGS;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_SUM} t_state;

    t_state                r_state;
    logic                  r_mode;
    logic [TEMPW-1:0]      r_start, r_soak_temp, r_peak_temp;
    logic [RATEW-1:0]      r_pre_rate, r_ramp_rate;
    logic [DURW-1:0]       r_soak_time, r_peak_time;
    logic [1:0]            r_job;
    logic [4:0]            r_cnt;
    logic [LENW-1:0]       r_work;
    logic [SPW-1:0]        r_rem, r_den;
    logic [LENW-1:0]       r_len0, r_len1, r_len2;
    logic [2:0]            r_k;
    logic [BXW-1:0]        r_acc;
    logic [5:0][BXW-1:0]   r_bx;
    logic [BXW:0]          r_door_sum;

    logic [TEMPW-1:0] from_t, to_t, diff;
    logic [RATEW-1:0] rate, rate_eff;
    logic             dbl;
    logic [LENW-1:0]  num;
    logic [SPW-1:0]   den;
    logic [SPW:0]     trial;
    logic             ge;
    logic [BXW-1:0]   inc, sum_new;
    logic [2:0]       nseg;

    assign nseg = r_mode ? N_STERIL : N_REFLOW;

    always_comb begin
        unique case (r_job)
            2'd0: begin
                from_t = r_start; to_t = r_soak_temp; rate = r_pre_rate; dbl = 1'b0;
            end
            2'd1: begin
                from_t = r_soak_temp; to_t = r_peak_temp; rate = r_ramp_rate; dbl = 1'b0;
            end
            default: begin
                from_t = r_start; to_t = r_mode ? r_soak_temp : r_peak_temp;
                rate = r_pre_rate; dbl = 1'b1;
            end
        endcase
        diff     = (to_t > from_t) ? to_t - from_t : '0;
        rate_eff = (rate == '0) ? RATEW'(1) : rate;
        num      = {diff, 12'b0};
        den      = dbl ? {rate_eff, 1'b0} : {1'b0, rate_eff};
        trial    = {r_rem, r_work[LENW-1]};
        ge       = trial >= {1'b0, r_den};
    end

    always_comb begin
        unique case (r_k)
            3'd1:    inc = BXW'(r_len0);
            3'd2:    inc = BXW'({r_soak_time, 4'b0});
            3'd3:    inc = r_mode ? BXW'(r_len2) : BXW'(r_len1);
            3'd4:    inc = r_mode ? '0 : BXW'({r_peak_time, 4'b0});
            3'd5:    inc = r_mode ? '0 : BXW'(r_len2);
            default: inc = '0;
        endcase
        sum_new = r_acc + inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_job       <= 2'd0;
            r_mode      <= 1'b0;
            r_start     <= 9'd25;
            r_pre_rate  <= 12'd384;
            r_soak_temp <= 9'd150;
            r_soak_time <= 10'd60;
            r_ramp_rate <= 12'd512;
            r_peak_temp <= 9'd230;
            r_peak_time <= 10'd20;
        end else if (i_cfg_valid) begin
            r_state <= S_LOAD;
            r_job   <= 2'd0;
            unique case (i_cfg_index)
                REG_MODE:      r_mode      <= i_cfg_data[0];
                REG_START:     r_start     <= i_cfg_data[TEMPW-1:0];
                REG_PRE_RATE:  r_pre_rate  <= i_cfg_data[RATEW-1:0];
                REG_SOAK_TEMP: r_soak_temp <= i_cfg_data[TEMPW-1:0];
                REG_SOAK_TIME: r_soak_time <= i_cfg_data[DURW-1:0];
                REG_RAMP_RATE: r_ramp_rate <= i_cfg_data[RATEW-1:0];
                REG_PEAK_TEMP: r_peak_temp <= i_cfg_data[TEMPW-1:0];
                REG_PEAK_TIME: r_peak_time <= i_cfg_data[DURW-1:0];
                default: ;
            endcase
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_LOAD: begin
                    r_work  <= num;
                    r_rem   <= '0;
                    r_den   <= den;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? SPW'(trial - {1'b0, r_den}) : SPW'(trial);
                    r_work <= {r_work[LENW-2:0], ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(LENW - 1)) begin
                        unique case (r_job)
                            2'd0:    r_len0 <= {r_work[LENW-2:0], ge};
                            2'd1:    r_len1 <= {r_work[LENW-2:0], ge};
                            default: r_len2 <= {r_work[LENW-2:0], ge};
                        endcase
                        if (r_job == 2'd2) begin
                            r_state <= S_SUM;
                            r_k     <= 3'd1;
                            r_acc   <= '0;
                            r_bx[0] <= '0;
                        end else begin
                            r_job   <= r_job + 2'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SUM: begin
                    r_bx[r_k] <= sum_new;
                    r_acc     <= sum_new;
                    r_k       <= r_k + 3'd1;
                    if (r_k == nseg)
                        r_door_sum <= {1'b0, r_acc} + {1'b0, sum_new};
                    if (r_k == 3'd5)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_prof.bx       = r_bx;
        o_prof.ty[0]    = r_start;
        o_prof.ty[1]    = r_soak_temp;
        o_prof.ty[2]    = r_soak_temp;
        o_prof.ty[3]    = r_mode ? ROOM_TEMP : r_peak_temp;
        o_prof.ty[4]    = r_mode ? ROOM_TEMP : r_peak_temp;
        o_prof.ty[5]    = ROOM_TEMP;
        o_prof.nseg     = nseg;
        o_prof.door_sum = r_door_sum;
        o_prof.busy     = (r_state != S_IDLE);
    end

endmodule

`default_nettype wire

// ===== sv/rps_front.sv =====
`default_nettype none

module rps_front import rps_pkg::*; #(
    parameter int MAX_SEGMENTS = 5
) (
    input  wire logic          i_in_valid,
    input  wire logic [TW-1:0] i_time_now,
    input  wire logic          i_full,
    input  t_profile           i_prof,
    output logic               o_in_ready,
    output logic               o_push,
    output t_job               o_job
);

    localparam logic [SEGW-1:0] SEG_NONE = SEGW'(MAX_SEGMENTS);

    logic [BXW-1:0] t_ext, lo, hi;
    logic           found;

    assign t_ext      = BXW'(i_time_now);
    assign o_in_ready = !i_prof.busy && !i_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        found      = 1'b0;
        lo         = '0;
        hi         = BXW'(1);
        o_job.seg  = SEG_NONE;
        o_job.mag  = '0;
        o_job.neg  = 1'b0;
        o_job.base = '0;
        for (int i = 0; i < 5; i++) begin
            if (!found && (3'(i) < i_prof.nseg) && t_ext >= i_prof.bx[i]
                    && t_ext < i_prof.bx[i+1]) begin
                found      = 1'b1;
                lo         = i_prof.bx[i];
                hi         = i_prof.bx[i+1];
                o_job.seg  = SEGW'(i);
                o_job.neg  = i_prof.ty[i+1] < i_prof.ty[i];
                o_job.mag  = (i_prof.ty[i+1] < i_prof.ty[i]) ?
                             i_prof.ty[i] - i_prof.ty[i+1] : i_prof.ty[i+1] - i_prof.ty[i];
                o_job.base = {i_prof.ty[i], 4'b0};
            end
        end
        o_job.dt   = found ? TW'(t_ext - lo) : '0;
        o_job.span = hi - lo;
        o_job.door = {{(BXW-TW){1'b0}}, i_time_now, 1'b0} > i_prof.door_sum;
    end

endmodule

`default_nettype wire

// ===== sv/rps_queue.sv =====
`default_nettype none

module rps_queue import rps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = $clog2(QDEPTH);

    t_job              r_mem [QDEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [PW:0]       r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PW+1)'(QDEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + PW'(1);
            if (i_pop)
                r_rd <= r_rd + PW'(1);
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/rps_back.sv =====
`default_nettype none

module rps_back import rps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_job            i_job,
    input  wire logic       i_avail,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [SPW-1:0]  o_setpoint,
    output logic [SEGW-1:0] o_segment_index,
    output logic            o_door_open
);

    localparam int CW = BXW + QW;

    typedef struct packed {
        logic [PRODW-1:0] p;
        logic [BXW-1:0]   span;
        logic [QW-1:0]    q;
        logic             neg;
        logic [SPW-1:0]   base;
        logic [SEGW-1:0]  seg;
        logic             door;
    } t_stage;

    t_stage    r_st [QW+1];
    t_stage    n_st [QW+1];
    logic [QW:0] r_v;
    logic      en;
    logic [CW-1:0] ext_p, ext_d;
    logic          ge;

    assign en    = !o_out_valid || i_out_ready;
    assign o_pop = en && i_avail;

    always_comb begin
        n_st[0].p    = {PRODW'(i_job.dt * i_job.mag)} << 4;
        n_st[0].span = i_job.span;
        n_st[0].q    = '0;
        n_st[0].neg  = i_job.neg;
        n_st[0].base = i_job.base;
        n_st[0].seg  = i_job.seg;
        n_st[0].door = i_job.door;
        ext_p = '0;
        ext_d = '0;
        ge    = 1'b0;
        for (int k = 1; k <= QW; k++) begin
            ext_p   = CW'(r_st[k-1].p);
            ext_d   = CW'(r_st[k-1].span) << (QW - k);
            ge      = ext_p >= ext_d;
            n_st[k] = r_st[k-1];
            if (ge) begin
                n_st[k].p         = PRODW'(ext_p - ext_d);
                n_st[k].q[QW - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= QW; k++)
                r_st[k] <= n_st[k];
            o_setpoint      <= r_st[QW].neg ? r_st[QW].base - r_st[QW].q
                                            : r_st[QW].base + r_st[QW].q;
            o_segment_index <= r_st[QW].seg;
            o_door_open     <= r_st[QW].door;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[QW-1:0], i_avail};
            o_out_valid <= r_v[QW];
        end
    end

endmodule

`default_nettype wire

// ===== sv/reflow_profile_setpoint.sv =====
// Oven setpoint from a piecewise-linear reflow or sterilize profile. One time word is taken
// per clock when no rebuild runs and the queue has room; one result word leaves per clock
// while i_out_ready is high. A word passes the queue write, a multiply stage, 13 divider
// stages of one quotient bit each and the output register. After reset and after every
// configuration write a bit-serial divider rebuilds the breakpoints (three ramp lengths,
// then a summing pass) and holds the input off; configuration writes are always taken.
`default_nettype none

module reflow_profile_setpoint import rps_pkg::*; #(
    parameter int MAX_SEGMENTS = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [TW-1:0]   i_time_now,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [SPW-1:0]       o_setpoint,
    output logic [SEGW-1:0]      o_segment_index,
    output logic                 o_door_open,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [IDXW-1:0] i_cfg_index,
    input  wire logic [CFGW-1:0] i_cfg_data
);

    t_profile prof;
    t_job     job_in, job_out;
    logic     push, pop, empty, full;

    assign o_cfg_ready = 1'b1;

    rps_bounds #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_bounds (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_prof      (prof)
    );

    rps_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_in_valid (i_in_valid),
        .i_time_now (i_time_now),
        .i_full     (full),
        .i_prof     (prof),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (job_in)
    );

    rps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty),
        .o_full  (full)
    );

    rps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job_out),
        .i_avail         (!empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_setpoint      (o_setpoint),
        .o_segment_index (o_segment_index),
        .o_door_open     (o_door_open)
    );

endmodule

`default_nettype wire

// ===== sv/rps_checker.sv =====
`default_nettype none

module rps_checker import rps_pkg::*; #(
    parameter int MAX_SEGMENTS = 5
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire logic [SPW-1:0]  o_setpoint,
    input wire logic [SEGW-1:0] o_segment_index,
    input wire logic            o_door_open,
    input wire logic            i_cfg_valid,
    input wire logic            o_cfg_ready
);

    localparam logic [SEGW-1:0] SEG_NONE = SEGW'(MAX_SEGMENTS);
    // the no-segment code only stands apart from real segments while it fits the field
    localparam bit NONE_UNIQUE = (MAX_SEGMENTS < (1 << SEGW));

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word after reset");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NONE_UNIQUE && o_out_valid && o_segment_index == SEG_NONE |-> o_setpoint == '0)
        else $error("nonzero setpoint outside profile");

    a_cfg_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("input taken during breakpoint rebuild");

    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_setpoint)
            && $stable(o_segment_index) && $stable(o_door_open))
        else $error("stalled result changed");

endmodule

bind reflow_profile_setpoint rps_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_rps_checker (.*);

`default_nettype wire
